@@ rtl/led_pwm_register_block_16ch_macros.svh @@
// ---------------------------------------------------------------------------
// LED PWM register block assertion macros
// Shared concurrent assertion forms used by the block's RTL.
// ---------------------------------------------------------------------------
`ifndef LED_PWM_REGISTER_BLOCK_16CH_MACROS_SVH
`define LED_PWM_REGISTER_BLOCK_16CH_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LPWM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lpwm assertion failed (same cycle)");

// Next-cycle implication, disabled while in reset
`define LPWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lpwm assertion failed (next cycle)");

`endif

@@ rtl/lpwm_pkg.sv @@
// ---------------------------------------------------------------------------
// LED PWM register block package
// Sizes, register addresses, request codes and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpwm_pkg;

  // Geometry
  localparam int CHANNELS      = 16;
  localparam int COUNTER_STEPS = 4096;
  localparam int CNT_W         = $clog2(COUNTER_STEPS);
  localparam int TICK_W        = 12;
  localparam int CMP_W         = (CNT_W > TICK_W) ? CNT_W : TICK_W;
  localparam int OUT_CH        = (CHANNELS < 16) ? CHANNELS : 16;
  localparam int CH_BYTES      = 4 * CHANNELS;

  // Address map
  localparam logic [7:0] ADDR_MODE     = 8'h00;
  localparam logic [7:0] ADDR_CH0      = 8'h06;
  localparam logic [7:0] ADDR_ALL      = 8'hFA;
  localparam logic [7:0] ADDR_PRESCALE = 8'hFE;
  localparam logic [8:0] CH_END        = 9'(6 + CH_BYTES);

  // Bit positions and reset values
  localparam int         SLEEP_POS    = 4;
  localparam int         FLAG_POS     = 4;
  localparam logic [7:0] MODE_RST     = 8'h10;
  localparam logic [7:0] PRESCALE_RST = 8'h1E;
  localparam logic [7:0] FLAG_MASK    = 8'h10;

  // Byte slots inside one channel
  localparam logic [1:0] BYTE_ON_LO  = 2'd0;
  localparam logic [1:0] BYTE_ON_HI  = 2'd1;
  localparam logic [1:0] BYTE_OFF_LO = 2'd2;
  localparam logic [1:0] BYTE_OFF_HI = 2'd3;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NOP   = 2'd3
  } lpwm_req_e;

  // Byte write into one channel
  typedef struct packed {
    logic       en;
    logic [1:0] sel;
    logic [7:0] data;
  } lpwm_wr_t;

  // Control status seen by the top level
  typedef struct packed {
    logic [7:0] mode;
    logic [7:0] prescale;
    logic       wrap;
  } lpwm_stat_t;

endpackage

`default_nettype wire

@@ rtl/lpwm_chan.sv @@
// ---------------------------------------------------------------------------
// LED PWM channel
// Four register bytes of one channel and its output compare.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpwm_chan
  import lpwm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lpwm_wr_t         wr_i,      // byte write into this channel
  input  wire logic [CNT_W-1:0] cnt_i,     // counter value after this step
  output logic      [3:0][7:0]  bytes_o,   // stored bytes, for reads
  output logic                  level_o    // level after this step
);

  logic [3:0][7:0]   bytes_q, bytes_d;
  logic [TICK_W-1:0] on_tick, off_tick;
  logic [CMP_W-1:0]  on_c, off_c, cnt_c;
  logic              full_on, full_off;

  // Byte write
  always_comb begin
    bytes_d = bytes_q;
    if (wr_i.en) begin
      bytes_d[wr_i.sel] = wr_i.data;
    end
  end

  // Off-high byte comes up with full-off set, all other bytes zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= {FLAG_MASK, 8'h00, 8'h00, 8'h00};
    end else begin
      bytes_q <= bytes_d;
    end
  end

  assign bytes_o = bytes_q;

  // Compare window on the updated bytes; full-off wins over full-on
  assign on_tick  = {bytes_d[BYTE_ON_HI][3:0], bytes_d[BYTE_ON_LO]};
  assign off_tick = {bytes_d[BYTE_OFF_HI][3:0], bytes_d[BYTE_OFF_LO]};
  assign full_on  = bytes_d[BYTE_ON_HI][FLAG_POS];
  assign full_off = bytes_d[BYTE_OFF_HI][FLAG_POS];
  assign on_c     = CMP_W'(on_tick);
  assign off_c    = CMP_W'(off_tick);
  assign cnt_c    = CMP_W'(cnt_i);

  always_comb begin
    if (full_off) begin
      level_o = 1'b0;
    end else if (full_on) begin
      level_o = 1'b1;
    end else if (on_c < off_c) begin
      level_o = (cnt_c >= on_c) && (cnt_c < off_c);
    end else if (on_c > off_c) begin
      level_o = (cnt_c >= on_c) || (cnt_c < off_c);
    end else begin
      level_o = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lpwm_ctrl.sv @@
// ---------------------------------------------------------------------------
// LED PWM control registers
// Mode and prescale bytes, prescaler and period counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "led_pwm_register_block_16ch_macros.svh"

module lpwm_ctrl
  import lpwm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             exec_i,   // request executes this cycle
  input  wire lpwm_req_e        req_i,
  input  wire logic [7:0]       addr_i,
  input  wire logic [7:0]       data_i,
  output lpwm_stat_t            stat_o,
  output logic      [CNT_W-1:0] cnt_d_o   // counter value after this step
);

  logic [7:0]       mode_q, mode_d;
  logic [7:0]       prescale_q, prescale_d;
  logic [7:0]       pre_cnt_q, pre_cnt_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wrap;

  // Register writes and tick stepping
  always_comb begin
    mode_d     = mode_q;
    prescale_d = prescale_q;
    pre_cnt_d  = pre_cnt_q;
    cnt_d      = cnt_q;
    wrap       = 1'b0;
    if (exec_i) begin
      case (req_i)
        REQ_WRITE: begin
          if (addr_i == ADDR_MODE) begin
            mode_d = data_i;
          end else if (addr_i == ADDR_PRESCALE && mode_q[SLEEP_POS]) begin
            prescale_d = data_i;
          end
        end
        REQ_TICK: begin
          // oscillator stopped while asleep
          if (!mode_q[SLEEP_POS]) begin
            if (pre_cnt_q >= prescale_q) begin
              pre_cnt_d = '0;
              if (cnt_q == CNT_W'(COUNTER_STEPS - 1)) begin
                cnt_d = '0;
                wrap  = 1'b1;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
            end else begin
              pre_cnt_d = pre_cnt_q + 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_RST;
      prescale_q <= PRESCALE_RST;
      pre_cnt_q  <= '0;
      cnt_q      <= '0;
    end else begin
      mode_q     <= mode_d;
      prescale_q <= prescale_d;
      pre_cnt_q  <= pre_cnt_d;
      cnt_q      <= cnt_d;
    end
  end

  assign stat_o.mode     = mode_q;
  assign stat_o.prescale = prescale_q;
  assign stat_o.wrap     = wrap;
  assign cnt_d_o         = cnt_d;

  // Counter frozen while asleep
  `LPWM_ASSERT_NEXT(a_sleep_hold, clk_i, rst_ni, mode_q[SLEEP_POS], cnt_q == $past(cnt_q))
  // Wrap only from the top count with the prescaler expired
  `LPWM_ASSERT_IMPL(a_wrap_top, clk_i, rst_ni, wrap, (cnt_q == CNT_W'(COUNTER_STEPS - 1)) && (pre_cnt_q >= prescale_q))

endmodule

`default_nettype wire

@@ rtl/led_pwm_register_block_16ch.sv @@
// Path: an accepted request is held in the input register, then executes into the result register.
// Throughput: one request per cycle while results are taken; a stalled result holds the
//   input register, and intake stops once that register is full as well.
// Reset: asynchronous, active low; all channels come up full-off, asleep,
//   prescale 0x1E, both counters at zero, no request or result held.
// ---------------------------------------------------------------------------
// LED PWM register block, 16 channels
// Byte register file with prescaled 12-bit PWM counter and channel compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "led_pwm_register_block_16ch_macros.svh"

module led_pwm_register_block_16ch
  import lpwm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [7:0] reg_addr, [15:8] write_data
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  // Result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [31:0] m_axis_tdata_o    // [7:0] read_data, [23:8] channel_outputs,
                                             // [24] period_start, [31:25] zero
);

  // Input register
  logic       in_valid_q;
  lpwm_req_e  in_req_q;
  logic [7:0] in_addr_q, in_data_q;
  logic       s_accept, exec;

  // Result register
  logic        out_valid_q;
  logic [7:0]  rd_q, rd_d;
  logic [15:0] lvl_q, lvl_d;
  logic        wrap_q;

  // Decode
  logic       is_wr, ch_hit, all_hit;
  logic [7:0] ch_off;
  logic [5:0] ch_sel;
  logic [1:0] byte_sel, all_sel;

  lpwm_stat_t       stat;
  logic [CNT_W-1:0] cnt_next;
  logic [3:0][7:0]  chan_bytes [CHANNELS];
  logic [CHANNELS-1:0] chan_lvl;

  // Handshake: a request executes once the result register can take it
  assign exec            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || exec;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (exec) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_req_q  <= lpwm_req_e'(s_axis_tuser_i);
      in_addr_q <= s_axis_tdata_i[7:0];
      in_data_q <= s_axis_tdata_i[15:8];
    end
  end

  // Address decode
  assign is_wr    = exec && (in_req_q == REQ_WRITE);
  assign ch_off   = in_addr_q - ADDR_CH0;
  assign ch_sel   = ch_off[7:2];
  assign byte_sel = ch_off[1:0];
  assign all_sel  = 2'(in_addr_q - ADDR_ALL);
  assign ch_hit   = (in_addr_q >= ADDR_CH0) && ({1'b0, in_addr_q} < CH_END) &&
                    (in_addr_q < ADDR_ALL);
  assign all_hit  = (in_addr_q >= ADDR_ALL) && (in_addr_q < ADDR_PRESCALE);

  lpwm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .exec_i  (exec),
    .req_i   (in_req_q),
    .addr_i  (in_addr_q),
    .data_i  (in_data_q),
    .stat_o  (stat),
    .cnt_d_o (cnt_next)
  );

  // Channel lanes
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    lpwm_wr_t wr;
    assign wr.en   = is_wr && (all_hit || (ch_hit && (ch_sel == 6'(c))));
    assign wr.sel  = all_hit ? all_sel : byte_sel;
    assign wr.data = in_data_q;

    lpwm_chan u_chan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (wr),
      .cnt_i   (cnt_next),
      .bytes_o (chan_bytes[c]),
      .level_o (chan_lvl[c])
    );
  end

  // Read data; all-channel and unused addresses read zero
  always_comb begin
    rd_d = '0;
    if (in_req_q == REQ_READ) begin
      if (in_addr_q == ADDR_MODE) begin
        rd_d = stat.mode;
      end else if (in_addr_q == ADDR_PRESCALE) begin
        rd_d = stat.prescale;
      end else if (ch_hit) begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (ch_sel == 6'(c)) begin
            rd_d = chan_bytes[c][byte_sel];
          end
        end
      end
    end
  end

  // Channel levels onto the 16-bit output field
  always_comb begin
    lvl_d = '0;
    for (int c = 0; c < OUT_CH; c++) begin
      lvl_d[c] = chan_lvl[c];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      rd_q   <= rd_d;
      lvl_q  <= lvl_d;
      wrap_q <= stat.wrap;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, wrap_q, lvl_q, rd_q};

  // A held request is never dropped
  `LPWM_ASSERT_NEXT(a_no_drop, clk_i, rst_ni, in_valid_q && !exec, in_valid_q)
  // An executed request always lands in the result register
  `LPWM_ASSERT_NEXT(a_exec_fills, clk_i, rst_ni, exec, out_valid_q)
  // Period start only comes from a tick
  `LPWM_ASSERT_IMPL(a_wrap_tick, clk_i, rst_ni, exec && stat.wrap, in_req_q == REQ_TICK)

endmodule

`default_nettype wire
